[design/vector_norm_unit_top_defines.svh]
// Assertion macros shared by the vector norm unit.
`ifndef VECTOR_NORM_UNIT_TOP_DEFINES_SVH
`define VECTOR_NORM_UNIT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold on every clock edge outside reset.
`define VNU_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("vector norm unit: invariant violated");
// Property whose consequent must hold in the cycle after its antecedent.
`define VNU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector norm unit: sequence violated");
`else
`define VNU_ASSERT_ALWAYS(label, clk, rst, prop)
`define VNU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/vnu_pkg.sv]
// Package of widths, mode codes, a helper function and control structs for the vector norm unit.
`timescale 1ns / 1ps

package vnu_pkg;

  localparam int IN_WIDTH     = 24;
  localparam int SAMPLE_WIDTH = 24;
  localparam int MAX_ELEMENTS = 65536;
  localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);
  localparam int MAG_W        = SAMPLE_WIDTH;
  localparam int SQ_W         = 2 * SAMPLE_WIDTH;
  localparam int TOTAL_W      = 64;
  localparam int NORM_W       = 40;
  localparam int MODE_W       = 2;
  localparam int SQRT_STEPS   = TOTAL_W / 2;
  localparam int STEP_W       = $clog2(SQRT_STEPS);

  localparam logic [MODE_W-1:0] MODE_L1   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_L2   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // an element request is taken this cycle
    logic sqrt_load;  // seed the square root unit from the total
    logic sqrt_step;  // run one square root iteration
    logic load_out;   // register the result and clear the accumulators
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_is_l2;
    logic sqrt_done;
  } status_t;

  // Magnitude of the low SAMPLE_WIDTH bits taken as a signed number.
  function automatic logic [MAG_W-1:0] magnitude(input logic [IN_WIDTH-1:0] raw);
    logic [MAG_W-1:0] v;
    v = raw[SAMPLE_WIDTH-1:0];
    if (v[SAMPLE_WIDTH-1]) begin
      magnitude = ~v + MAG_W'(1);
    end else begin
      magnitude = v;
    end
  endfunction

endpackage

[design/vnu_ctrl.sv]
// Controller state machine of the vector norm unit.
`timescale 1ns / 1ps

module vnu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             is_last,
  input  logic             out_stall,
  input  vnu_pkg::status_t status,
  output logic             in_stall,
  output logic             out_valid,
  output vnu_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_RUN   = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_RUN);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      S_RUN: begin
        cmd.accept = in_valid;
        if (in_valid && is_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.sqrt_load = 1'b1;
        state_next    = status.mode_is_l2 ? S_SQRT : S_FINAL;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_done) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.load_out = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

endmodule

[design/vnu_datapath.sv]
// Datapath of the vector norm unit: square stage, accumulator, square root unit, result register.
`timescale 1ns / 1ps

module vnu_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [vnu_pkg::MODE_W-1:0]         cfg_wr_data,
  input  logic signed [vnu_pkg::IN_WIDTH-1:0] element_value,
  input  vnu_pkg::cmd_t                      cmd,
  output vnu_pkg::status_t                   status,
  output logic [vnu_pkg::NORM_W-1:0]         norm_value,
  output logic                               saturated
);

  logic [vnu_pkg::MODE_W-1:0]  mode;
  logic                        s1_valid;
  logic                        s1_add;
  logic [vnu_pkg::MAG_W-1:0]   s1_mag;
  logic [vnu_pkg::SQ_W-1:0]    s1_sq;
  logic [vnu_pkg::TOTAL_W-1:0] total;
  logic [vnu_pkg::TOTAL_W-1:0] total_next;
  logic [vnu_pkg::COUNT_W-1:0] count;
  logic                        overflow_seen;
  logic                        count_full;
  logic                        add_carry;
  logic [vnu_pkg::TOTAL_W:0]   sum;
  logic [vnu_pkg::TOTAL_W-1:0] addend;
  logic [vnu_pkg::MAG_W-1:0]   in_mag;

  logic [vnu_pkg::TOTAL_W-1:0] rem;
  logic [vnu_pkg::TOTAL_W-1:0] root;
  logic [vnu_pkg::TOTAL_W-1:0] sq_bit;
  logic [vnu_pkg::TOTAL_W-1:0] trial;
  logic [vnu_pkg::STEP_W-1:0]  step;
  logic [vnu_pkg::TOTAL_W-1:0] norm_full;

  assign in_mag     = vnu_pkg::magnitude(element_value);
  assign count_full = (count >= vnu_pkg::COUNT_W'(vnu_pkg::MAX_ELEMENTS));

  // Accumulate the element held in the square stage.
  always_comb begin
    addend = (mode == vnu_pkg::MODE_L2) ? vnu_pkg::TOTAL_W'(s1_sq)
                                        : vnu_pkg::TOTAL_W'(s1_mag);
    sum        = {1'b0, total} + {1'b0, addend};
    add_carry  = 1'b0;
    total_next = total;
    unique case (mode)
      vnu_pkg::MODE_L1, vnu_pkg::MODE_L2: begin
        add_carry  = sum[vnu_pkg::TOTAL_W];
        total_next = add_carry ? '1 : sum[vnu_pkg::TOTAL_W-1:0];
      end
      vnu_pkg::MODE_MAX: begin
        if (vnu_pkg::TOTAL_W'(s1_mag) > total) begin
          total_next = vnu_pkg::TOTAL_W'(s1_mag);
        end
      end
      vnu_pkg::MODE_NONE: begin
        total_next = total;
      end
      default: begin
        total_next = total;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= vnu_pkg::MODE_L2;
      s1_valid      <= 1'b0;
      total         <= '0;
      count         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      s1_valid <= cmd.accept;
      if (cmd.load_out) begin
        total         <= '0;
        count         <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (cmd.accept && !count_full) begin
          count <= count + vnu_pkg::COUNT_W'(1);
        end
        if (s1_valid && s1_add) begin
          total <= total_next;
        end
        overflow_seen <= overflow_seen | (cmd.accept && count_full)
                       | (s1_valid && s1_add && add_carry);
      end
    end
  end

  // Square stage: magnitude and its square are registered on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s1_add <= !count_full;
      s1_mag <= in_mag;
      s1_sq  <= vnu_pkg::SQ_W'(in_mag) * vnu_pkg::SQ_W'(in_mag);
    end
  end

  // Digit-by-digit integer square root, two bits of the radicand per cycle.
  assign trial = root + sq_bit;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      rem    <= total;
      root   <= '0;
      sq_bit <= vnu_pkg::TOTAL_W'(1) << (vnu_pkg::TOTAL_W - 2);
      step   <= '0;
    end else if (cmd.sqrt_step) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + sq_bit;
      end else begin
        root <= root >> 1;
      end
      sq_bit <= sq_bit >> 2;
      step   <= step + vnu_pkg::STEP_W'(1);
    end
  end

  assign status.mode_is_l2 = (mode == vnu_pkg::MODE_L2);
  assign status.sqrt_done  = (step == vnu_pkg::STEP_W'(vnu_pkg::SQRT_STEPS - 1));

  always_comb begin
    unique case (mode)
      vnu_pkg::MODE_L1, vnu_pkg::MODE_MAX: norm_full = total;
      vnu_pkg::MODE_L2:                    norm_full = root;
      vnu_pkg::MODE_NONE:                  norm_full = '0;
      default:                             norm_full = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (norm_full[vnu_pkg::TOTAL_W-1:vnu_pkg::NORM_W] != '0) begin
        norm_value <= '1;
        saturated  <= 1'b1;
      end else begin
        norm_value <= norm_full[vnu_pkg::NORM_W-1:0];
        saturated  <= overflow_seen;
      end
    end
  end

endmodule

[design/vector_norm_unit_top.sv]
// Top level of the vector norm unit: controller, datapath and assertions.
// Elements are taken one per cycle while in_stall is low; the vector's norm is registered
// after its last element, as the controller passes drain, seed, the 32-step square root
// (2-norm only) and result load and raises out_valid; then the next vector is taken.
// Synchronous active-high reset clears the accumulators, the element counter and the state
// machine, and sets the mode register to the euclidean norm.
`timescale 1ns / 1ps

`include "vector_norm_unit_top_defines.svh"

module vector_norm_unit_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [vnu_pkg::MODE_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [vnu_pkg::IN_WIDTH-1:0] element_value,
  input  logic                                is_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [vnu_pkg::NORM_W-1:0]          norm_value,
  output logic                                saturated
);

  // The controller sequences the vector end; the datapath does all arithmetic.
  vnu_pkg::cmd_t    cmd;
  vnu_pkg::status_t status;

  // Within a vector the controller stays in its run state and takes one element request
  // per cycle. The last element sends it through drain, seed, the optional square root
  // loop and the result load before it offers the result request.
  vnu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_last   (is_last),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath registers each magnitude and its square in the cycle of its request and in the
  // next cycle adds one of them to the 64-bit total, saturating on carry, or keeps the maximum.
  // The result register holds the norm until the result request is taken.
  vnu_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .element_value (element_value),
    .cmd           (cmd),
    .status        (status),
    .norm_value    (norm_value),
    .saturated     (saturated)
  );

  // The block never takes an element request while a result request is pending.
  `VNU_ASSERT_ALWAYS(a_no_accept_with_result, clk, rst, !(out_valid && !in_stall))
  // The last element of a vector closes the input until its result is delivered.
  `VNU_ASSERT_NEXT(a_last_stalls_input, clk, rst, in_valid && !in_stall && is_last, in_stall)
  // A delivered result is not offered a second time.
  `VNU_ASSERT_NEXT(a_result_once, clk, rst, out_valid && !out_stall, !out_valid)

endmodule

[tb/sv/vector_norm_unit_top_tb.sv]
// Self-checking testbench for the vector norm unit: directed and random tests.
`timescale 1ns / 1ps

module vector_norm_unit_top_tb;

  // The run is cut off here. A correct run's length is set mostly by the square root per
  // 2-norm vector and the quiet waits around mode writes.
  localparam int CYCLE_LIMIT = 500_000;
  // Cycles to let pass after the last expected result.
  localparam int SETTLE_CYCLES = 40;
  localparam logic [63:0] NORM_CEILING = (64'd1 << vnu_pkg::NORM_W) - 64'd1;
  localparam logic signed [vnu_pkg::IN_WIDTH-1:0] ELEM_MAX =
    {1'b0, {(vnu_pkg::IN_WIDTH-1){1'b1}}};
  localparam logic signed [vnu_pkg::IN_WIDTH-1:0] ELEM_MIN =
    {1'b1, {(vnu_pkg::IN_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [vnu_pkg::NORM_W-1:0] norm;
    logic                       sat;
  } norm_result_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_wr_en;
  logic [vnu_pkg::MODE_W-1:0]          cfg_wr_data;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [vnu_pkg::IN_WIDTH-1:0] element_value;
  logic                                is_last;
  logic                                out_valid;
  logic                                out_stall;
  logic [vnu_pkg::NORM_W-1:0]          norm_value;
  logic                                saturated;

  // Shadow copy of the block's mode register and accumulators; the accumulators advance on every accepted request.
  logic [vnu_pkg::MODE_W-1:0]  mode_shadow;
  logic [63:0]                 acc_total;
  logic [16:0]                 acc_count;
  logic                        acc_overflow;

  // Norms predicted for finished vectors, oldest first.
  norm_result_t       pending_norms[$];

  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 error_count;
  int                 cycle_count;

  vector_norm_unit_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_value (element_value),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .norm_value    (norm_value),
    .saturated     (saturated)
  );

  always #5 clk = ~clk;

  // The result side stalls at random; the rate is set per phase. It changes on the
  // falling edge so that the block sees a settled value at the rising edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Every result taken at a rising edge is matched against the oldest predicted norm.
  // Values are read right after the edge, before the block's own updates land.
  always @(posedge clk) begin
    norm_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_norms.size() == 0) begin
        $display("%0t: unexpected result norm_value %0d saturated %0b", $time,
                 norm_value, saturated);
        error_count++;
      end else begin
        want = pending_norms.pop_front();
        if (norm_value !== want.norm) begin
          $display("%0t: norm_value expected %0d actual %0d", $time, want.norm, norm_value);
          error_count++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, want.sat, saturated);
          error_count++;
        end
      end
    end
  end

  // A hung handshake must not keep the run going forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Magnitude of a signed sample; the most negative value maps to 2^23 exactly.
  function automatic logic [vnu_pkg::IN_WIDTH-1:0] abs_sample(
    input logic signed [vnu_pkg::IN_WIDTH-1:0] v);
    abs_sample = v[vnu_pkg::IN_WIDTH-1] ? vnu_pkg::IN_WIDTH'(-v) : vnu_pkg::IN_WIDTH'(v);
  endfunction

  // Floor square root by setting root bits from the top down.
  function automatic logic [31:0] root_floor(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    logic [63:0] square;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      square = 64'(trial) * 64'(trial);
      if (square <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Adds into the running total, pinning it at all ones on a carry out.
  function automatic void add_to_total(input logic [63:0] addend);
    logic [64:0] sum;
    sum = {1'b0, acc_total} + {1'b0, addend};
    if (sum[64]) begin
      acc_overflow = 1'b1;
      acc_total = '1;
    end else begin
      acc_total = sum[63:0];
    end
  endfunction

  // Folds one accepted element into the shadow state and, on the last element,
  // queues the norm that the block must return for the vector.
  function automatic void fold_element(input logic signed [vnu_pkg::IN_WIDTH-1:0] v,
                                       input logic last);
    logic [vnu_pkg::IN_WIDTH-1:0] mag;
    logic [63:0]                  full;
    norm_result_t                 res;
    mag = abs_sample(v);
    if (acc_count >= 17'(vnu_pkg::MAX_ELEMENTS)) begin
      acc_overflow = 1'b1;
    end else begin
      acc_count++;
      case (mode_shadow)
        vnu_pkg::MODE_L1:  add_to_total(64'(mag));
        vnu_pkg::MODE_L2:  add_to_total(64'(mag) * 64'(mag));
        vnu_pkg::MODE_MAX: if (64'(mag) > acc_total) acc_total = 64'(mag);
        default:           ;
      endcase
    end
    if (last) begin
      case (mode_shadow)
        vnu_pkg::MODE_L1, vnu_pkg::MODE_MAX: full = acc_total;
        vnu_pkg::MODE_L2:                    full = 64'(root_floor(acc_total));
        default:                             full = '0;
      endcase
      res.sat = acc_overflow;
      if (full > NORM_CEILING) begin
        full = NORM_CEILING;
        res.sat = 1'b1;
      end
      res.norm = full[vnu_pkg::NORM_W-1:0];
      pending_norms.push_back(res);
      acc_total = '0;
      acc_count = '0;
      acc_overflow = 1'b0;
    end
  endfunction

  // Random element: mostly full-range values, with extremes and small values mixed in.
  function automatic logic signed [vnu_pkg::IN_WIDTH-1:0] random_element();
    logic signed [vnu_pkg::IN_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      4: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = 1;
          2:       v = -1;
          3:       v = ELEM_MAX;
          default: v = ELEM_MIN;
        endcase
      end
      5, 6:    v = vnu_pkg::IN_WIDTH'($signed($urandom_range(0, 511)) - 256);
      default: v = vnu_pkg::IN_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  // Sends one element request. Entered and left at a falling edge. The sender may
  // hold off first with valid low; valid then stays high until the request is taken.
  task automatic send_element(input logic signed [vnu_pkg::IN_WIDTH-1:0] v,
                              input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    element_value = v;
    is_last = last;
    do begin
      @(posedge clk);
    end while (in_stall);
    fold_element(v, last);
    @(negedge clk);
  endtask

  // Lets every predicted norm come back, then waits out the longest latency, so that
  // the block holds no work at all. Entered and left at a falling edge.
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (pending_norms.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes the mode register; only called while the block is quiet.
  task automatic write_mode(input logic [vnu_pkg::MODE_W-1:0] m);
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(posedge clk);
    mode_shadow = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // The mode after reset must be the euclidean norm: 3.0 and 4.0 give 5.0.
  task automatic test_reset_mode();
    send_element(24'sh030000, 1'b0);
    send_element(-24'sh040000, 1'b1);
    wait_quiet();
  endtask

  // Zero, one, minus one, the largest and the most negative element in the 1-norm, 2-norm and max modes.
  // The unsupported mode gets a lone element, which is also the shortest vector.
  task automatic test_field_extremes();
    logic [vnu_pkg::MODE_W-1:0] modes[3];
    modes = '{vnu_pkg::MODE_L1, vnu_pkg::MODE_L2, vnu_pkg::MODE_MAX};
    foreach (modes[k]) begin
      write_mode(modes[k]);
      send_element('0, 1'b0);
      send_element(1, 1'b0);
      send_element(-1, 1'b0);
      send_element(ELEM_MAX, 1'b0);
      send_element(ELEM_MIN, 1'b1);
      wait_quiet();
    end
    write_mode(vnu_pkg::MODE_NONE);
    send_element(ELEM_MIN, 1'b1);
    wait_quiet();
  endtask

  // The mode switches between elements of one vector; each element is folded by the
  // mode in force when it is taken, and the result follows the mode at the last one.
  task automatic test_mode_change_mid_vector();
    write_mode(vnu_pkg::MODE_L1);
    send_element(24'sh012345, 1'b0);
    send_element(-24'sh000400, 1'b0);
    send_element(24'sh000077, 1'b0);
    wait_quiet();
    write_mode(vnu_pkg::MODE_MAX);
    send_element(24'sh000100, 1'b0);
    send_element(-24'sh000010, 1'b1);
    wait_quiet();
  endtask

  // Random vectors, mostly short, with the mode rewritten now and then while quiet.
  task automatic test_random_vectors(input int request_count);
    int sent;
    int len;
    sent = 0;
    write_mode(vnu_pkg::MODE_W'($urandom_range(0, 3)));
    while (sent < request_count) begin
      if ($urandom_range(0, 14) == 0) begin
        wait_quiet();
        write_mode(vnu_pkg::MODE_W'($urandom_range(0, 3)));
      end
      case ($urandom_range(0, 99))
        0, 1, 2:                  len = $urandom_range(41, 120);
        3, 4, 5, 6, 7, 8, 9, 10,
        11, 12, 13, 14:           len = $urandom_range(7, 40);
        default:                  len = $urandom_range(1, 6);
      endcase
      for (int i = 0; i < len; i++) begin
        send_element(random_element(), i == len - 1);
      end
      sent += len;
    end
    wait_quiet();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    element_value = '0;
    is_last = 1'b0;
    out_stall = 1'b0;
    mode_shadow = vnu_pkg::MODE_L2;
    acc_total = '0;
    acc_count = '0;
    acc_overflow = 1'b0;
    error_count = 0;
    cycle_count = 0;
    tx_idle_pct = 19;
    rx_idle_pct = 51;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed tests and the first random phase: light sender gaps, heavy result stalls.
    test_reset_mode();
    test_field_extremes();
    test_mode_change_mid_vector();
    test_random_vectors(640);

    // Second phase: the sender idles often while results are mostly taken at once.
    tx_idle_pct = 51;
    rx_idle_pct = 19;
    test_random_vectors(640);

    // Last phase: no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_vectors(640);

    wait_quiet();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[vector_norm_unit_top.f]
+incdir+design
design/vnu_pkg.sv
design/vnu_ctrl.sv
design/vnu_datapath.sv
design/vector_norm_unit_top.sv
tb/sv/vector_norm_unit_top_tb.sv
